@@ design/brf_pkg.sv @@
// Shared types and constants for the breadth-first route finder.
// No dependencies; imported by every module of the block.
package brf_pkg;
	localparam int NODES  = 16;
	localparam int NODE_W = 4;
	localparam int CNT_W  = 5;

	typedef logic [NODE_W-1:0] node_t;
	typedef logic [NODES-1:0]  row_t;
	typedef logic [CNT_W-1:0]  cnt_t;

	localparam node_t LAST_NODE  = node_t'(NODES - 1);
	localparam cnt_t  NODES_CNT  = cnt_t'(NODES);
	localparam cnt_t  LAST_CNT   = cnt_t'(NODES - 1);

	localparam logic ACT_LOAD  = 1'b0;
	localparam logic ACT_ROUTE = 1'b1;

	typedef struct packed {
		logic  en;
		node_t idx;
		row_t  bits;
	} adj_wr_t;
endpackage

@@ design/brf_adjacency.sv @@
// Adjacency bit matrix: one row written per load beat, one row read for the scan.
// Depends on brf_pkg.
module brf_adjacency (
	input  logic             clk,
	input  logic             arst_n,
	input  brf_pkg::adj_wr_t wr,
	input  brf_pkg::node_t   rd_idx,
	output brf_pkg::row_t    rd_row
);
	import brf_pkg::*;

	row_t rows_q [NODES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NODES; i++) rows_q[i] <= '0;
		end else if (wr.en) begin
			rows_q[wr.idx] <= wr.bits;
		end
	end

	assign rd_row = rows_q[rd_idx];
endmodule

@@ design/brf_search.sv @@
// Search sequencer: breadth-first scan one neighbor bit per cycle, backtrack, emit.
// Depends on brf_pkg; reads rows from brf_adjacency.
module brf_search (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           query,
	input  brf_pkg::node_t origin,
	input  brf_pkg::node_t destination,
	output brf_pkg::node_t rd_idx,
	input  brf_pkg::row_t  rd_row,
	output logic           busy,
	output logic           result_valid,
	output brf_pkg::node_t route_node,
	output logic           last,
	output logic           reached
);
	import brf_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DEQ,
		ST_SCAN,
		ST_TRACE,
		ST_EMIT
	} state_t;

	state_t state_q;
	node_t  org_q, dst_q, u_q, v_q, cur_q;
	cnt_t   head_q, tail_q, depth_q;
	row_t   visited_q, predv_q;
	node_t  queue_q [NODES];
	node_t  pred_q  [NODES];
	node_t  stack_q [NODES];
	logic   reached_q, valid_q, last_q;
	node_t  node_q;
	node_t  head_node;
	logic   hit;

	assign rd_idx    = u_q;
	assign head_node = queue_q[head_q[NODE_W-1:0]];
	assign hit       = rd_row[v_q] && !visited_q[v_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			valid_q   <= 1'b0;
			visited_q <= '0;
			predv_q   <= '0;
			head_q    <= '0;
			tail_q    <= '0;
			depth_q   <= '0;
			org_q     <= '0;
			dst_q     <= '0;
			u_q       <= '0;
			v_q       <= '0;
			cur_q     <= '0;
			reached_q <= 1'b0;
			last_q    <= 1'b0;
			node_q    <= '0;
			for (int i = 0; i < NODES; i++) begin
				queue_q[i] <= '0;
				pred_q[i]  <= '0;
				stack_q[i] <= '0;
			end
		end else begin
			valid_q <= (state_q == ST_EMIT);
			case (state_q)
				ST_IDLE: begin
					if (query) begin
						org_q      <= origin;
						dst_q      <= destination;
						visited_q  <= row_t'(1) << origin;
						predv_q    <= '0;
						queue_q[0] <= origin;
						head_q     <= '0;
						tail_q     <= cnt_t'(1);
						state_q    <= ST_DEQ;
					end
				end
				ST_DEQ: begin
					if (head_q == tail_q || head_node == dst_q) begin
						cur_q   <= dst_q;
						depth_q <= '0;
						state_q <= ST_TRACE;
					end else begin
						u_q     <= head_node;
						v_q     <= '0;
						state_q <= ST_SCAN;
					end
					if (head_q != tail_q) head_q <= head_q + cnt_t'(1);
				end
				ST_SCAN: begin
					if (hit) begin
						visited_q[v_q] <= 1'b1;
						predv_q[v_q]   <= 1'b1;
						pred_q[v_q]    <= u_q;
						if (tail_q < NODES_CNT) begin
							queue_q[tail_q[NODE_W-1:0]] <= v_q;
							tail_q <= tail_q + cnt_t'(1);
						end
					end
					v_q <= v_q + node_t'(1);
					if (v_q == LAST_NODE) state_q <= ST_DEQ;
				end
				ST_TRACE: begin
					stack_q[depth_q[NODE_W-1:0]] <= cur_q;
					depth_q <= depth_q + cnt_t'(1);
					if (!predv_q[cur_q] || depth_q == LAST_CNT) begin
						reached_q <= (cur_q == org_q);
						state_q   <= ST_EMIT;
					end else begin
						cur_q <= pred_q[cur_q];
					end
				end
				ST_EMIT: begin
					node_q  <= stack_q[depth_q[NODE_W-1:0] - node_t'(1)];
					last_q  <= (depth_q == cnt_t'(1));
					depth_q <= depth_q - cnt_t'(1);
					if (depth_q == cnt_t'(1)) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy         = (state_q != ST_IDLE);
	assign result_valid = valid_q;
	assign route_node   = node_q;
	assign last         = last_q;
	assign reached      = reached_q;
endmodule

@@ design/bfs_route_finder.sv @@
// Top level of the breadth-first route finder: command port, adjacency store, search.
// Depends on brf_pkg, brf_adjacency and brf_search.
//
// A load beat (action 0) writes one adjacency row and leaves busy low.
// A route beat (action 1) raises busy while the search sequencer runs: a dequeue step
// per queued node plus a scan step per neighbor bit tested (16 per dequeued node),
// then a backtrack step per path node and an emit step per result.
// Results appear one per cycle on route_node/last/reached while result_valid is high;
// the receiver cannot stall, so every result must be taken in the cycle it is shown.
// The neighbor scan, one adjacency bit per cycle, sets the query time.
module bfs_route_finder (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  logic           action,
	input  brf_pkg::node_t row_index,
	input  brf_pkg::row_t  row_bits,
	input  brf_pkg::node_t origin,
	input  brf_pkg::node_t destination,
	output logic           result_valid,
	output brf_pkg::node_t route_node,
	output logic           last,
	output logic           reached
);
	import brf_pkg::*;

	logic    accept;
	adj_wr_t adj_wr;
	node_t   rd_idx;
	row_t    rd_row;

	assign accept      = start && !busy;
	assign adj_wr.en   = accept && (action == ACT_LOAD);
	assign adj_wr.idx  = row_index;
	assign adj_wr.bits = row_bits;

	brf_adjacency u_adj (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (adj_wr),
		.rd_idx (rd_idx),
		.rd_row (rd_row)
	);

	brf_search u_search (
		.clk          (clk),
		.arst_n       (arst_n),
		.query        (accept && (action == ACT_ROUTE)),
		.origin       (origin),
		.destination  (destination),
		.rd_idx       (rd_idx),
		.rd_row       (rd_row),
		.busy         (busy),
		.result_valid (result_valid),
		.route_node   (route_node),
		.last         (last),
		.reached      (reached)
	);
endmodule
